>>> src/khsc_pkg.sv
// Shared types, constants and hash fold function for the keyword hash slot checker.
package khsc_pkg;

    localparam logic [63:0] SEED_RESET = 64'd7279593577997237667;
    localparam logic [63:0] FOLD_MASK  = 64'h0000_0000_f000_0000;
    localparam int          FOLD_SHIFT = 24;
    localparam int          CHAR_SHIFT = 5;
    localparam int          SLOT_SHIFT = 56;
    localparam int          SLOT_BITS  = 8;
    localparam logic [7:0]  CNT_MAX    = 8'hff;

    // Register indexes on the config port (index = paddr[3]).
    localparam logic REG_SEED = 1'b0;
    localparam logic REG_MAXC = 1'b1;

    // Item kinds.
    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL0   = 6'b000010,
        S_MUL1   = 6'b000100,
        S_MUL2   = 6'b001000,
        S_SUM    = 6'b010000,
        S_UPDATE = 6'b100000
    } t_state;

    // One PJW-style step: shift left by five and add the byte, fold bits 31:28 down into 7:4.
    function automatic logic [63:0] f_fold(input logic [63:0] h, input logic [7:0] c);
        logic [63:0] t;
        logic [63:0] g;
        t = (h << CHAR_SHIFT) + {56'd0, c};
        g = t & FOLD_MASK;
        return t ^ (g >> FOLD_SHIFT) ^ g;
    endfunction

endpackage

>>> src/keyword_hash_slot_checker.sv
// Keyword hash slot checker: byte-serial PJW-style hash, seeded slot hash, slot occupancy check.
// Character and clear items never raise busy. A final byte raises busy through S_MUL0,
//   S_MUL1 and S_MUL2 (3 passes of the shared 32x32 multiplier), S_SUM (an accumulate with
//   the counter read) and S_UPDATE (a counter update); o_valid is registered from S_UPDATE.
// No item is accepted while busy is high; the receiver cannot stall.
// Reset (synchronous, active low): seed and limit to defaults, hash, counters and failure clear.
module keyword_hash_slot_checker
    import khsc_pkg::*;
#(
    parameter int SLOT_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item port
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    // result port
    output logic        o_valid,
    output logic [7:0]  o_slot_index,
    output logic [63:0] o_signature,
    output logic [7:0]  o_prior_occupancy,
    output logic        o_still_fits,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // Only the first 256 counters are reachable; fewer slots wrap the index.
    localparam int EFF = (SLOT_COUNT < 256) ? SLOT_COUNT : 256;
    localparam int IW  = $clog2(EFF);

    typedef logic [IW-1:0] t_slot_map [256];

    function automatic t_slot_map f_build_map();
        t_slot_map m;
        for (int i = 0; i < 256; i++) begin
            m[i] = IW'(i % SLOT_COUNT);
        end
        return m;
    endfunction

    localparam t_slot_map SLOT_MAP = f_build_map();

    // config registers
    logic [63:0] r_seed;
    logic [7:0]  r_max_coll;

    // control
    t_state      r_state, n_state;
    logic [63:0] r_hash;
    logic        r_failed;
    logic [EFF-1:0] r_cnt_vld;

    // datapath
    logic [63:0] r_sig;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [IW-1:0] r_idx;
    logic [7:0]  r_rd_data;
    logic        r_rd_vld;
    logic [7:0]  r_cnt_mem [EFF];

    logic        acc_item;
    logic        cfg_wr;
    logic [63:0] folded;
    logic [31:0] mul_a, mul_b;
    logic [31:0] acc_hi_sum;
    logic [7:0]  prior;
    logic        over;
    logic [IW-1:0] slot_idx;

    assign acc_item = start && !busy;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign folded   = f_fold(r_hash, i_char_code);
    assign busy     = (r_state != S_IDLE);
    assign pready   = 1'b1;

    always_comb begin
        unique case (paddr[3])
            REG_SEED: prdata = r_seed;
            REG_MAXC: prdata = {56'd0, r_max_coll};
            default:  prdata = '0;
        endcase
    end

    // Shared multiplier operand select: lo*lo, then the two cross terms.
    always_comb begin
        mul_a = r_seed[31:0];
        mul_b = r_sig[31:0];
        unique case (r_state)
            S_MUL1:  mul_b = r_sig[63:32];
            S_MUL2:  mul_a = r_seed[63:32];
            default: ;
        endcase
    end

    // Cross terms only reach bits 63:32 of the product mod 2^64.
    assign acc_hi_sum = r_acc[63:32] + r_prod[31:0];
    // In S_SUM the adder output already holds the last cross term, so the slot
    // is taken from it directly for the counter read.
    assign slot_idx   = SLOT_MAP[acc_hi_sum[(SLOT_SHIFT - 32) +: SLOT_BITS]];

    assign prior = r_rd_vld ? r_rd_data : 8'd0;
    assign over  = (prior > r_max_coll);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (acc_item && i_kind == KIND_CHAR && i_last_char) n_state = S_MUL0;
            S_MUL0:   n_state = S_MUL1;
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_SUM;
            S_SUM:    n_state = S_UPDATE;
            S_UPDATE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_seed     <= SEED_RESET;
            r_max_coll <= 8'd0;
            r_hash     <= '0;
            r_failed   <= 1'b0;
            r_cnt_vld  <= '0;
            o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == S_UPDATE);
            if (cfg_wr) begin
                unique case (paddr[3])
                    REG_SEED: r_seed     <= pwdata;
                    REG_MAXC: r_max_coll <= pwdata[7:0];
                    default:  ;
                endcase
            end
            if (acc_item) begin
                if (i_kind == KIND_CLEAR) begin
                    r_failed  <= 1'b0;
                    r_cnt_vld <= '0;
                end else begin
                    r_hash <= i_last_char ? 64'd0 : folded;
                end
            end
            if (r_state == S_UPDATE) begin
                if (over) begin
                    r_failed <= 1'b1;
                end else begin
                    r_cnt_vld[r_idx] <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (acc_item && i_kind == KIND_CHAR && i_last_char) begin
            r_sig <= folded;
        end
        r_prod <= {32'd0, mul_a} * {32'd0, mul_b};
        case (r_state)
            S_MUL1:  r_acc <= r_prod;
            S_MUL2,
            S_SUM:   r_acc[63:32] <= acc_hi_sum;
            default: ;
        endcase
        if (r_state == S_UPDATE) begin
            o_slot_index      <= r_acc[SLOT_SHIFT +: SLOT_BITS];
            o_signature       <= r_sig;
            o_prior_occupancy <= prior;
            o_still_fits      <= !(r_failed || over);
        end
    end

    // slot counter memory: read issued at end of S_SUM, write in S_UPDATE
    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM) begin
            r_idx     <= slot_idx;
            r_rd_data <= r_cnt_mem[slot_idx];
            r_rd_vld  <= r_cnt_vld[slot_idx];
        end
        if (r_state == S_UPDATE && !over) begin
            r_cnt_mem[r_idx] <= (prior == CNT_MAX) ? CNT_MAX : prior + 8'd1;
        end
    end

endmodule

>>> src/khsc_chk.sv
// Port-level assertions for the keyword hash slot checker, bound to the top level.
module khsc_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_kind,
    input logic i_last_char,
    input logic o_valid,
    input logic pready
);

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

    a_final_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && start && !busy && !i_kind && i_last_char) |=> busy)
        else $error("final byte did not start slot check");

    a_short_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && start && !busy && (i_kind || !i_last_char)) |=> !busy)
        else $error("byte or clear item raised busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind keyword_hash_slot_checker khsc_chk u_khsc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_kind      (i_kind),
    .i_last_char (i_last_char),
    .o_valid     (o_valid),
    .pready      (pready)
);
